// ===== rtl/crcd_pkg.sv =====
package crcd_pkg;

    localparam int PAYLOAD_MAX = 64;
    localparam int HDR_BYTES   = 12;
    localparam int LEN_W       = 7;
    localparam int OFS_W       = 6;
    localparam int ADDR_W      = OFS_W + 1;
    localparam int HIDX_W      = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic REG_SYNC    = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef struct packed {
        logic              slot;
        logic [7:0]        frame_type;
        logic [31:0]       sequence_res;
        logic [LEN_W-1:0]  length;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic [1:0] count;
        logic       avail;
        desc_t      head;
    } q_status_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crcd_front.sv =====
module crcd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         rx_byte,
    output logic               full,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [31:0]        wr_data,
    input  crcd_pkg::q_status_t q_status,
    output logic               desc_push,
    output crcd_pkg::desc_t    desc,
    output crcd_pkg::mem_wr_t  mem_wr
);
    import crcd_pkg::*;

    typedef enum logic [2:0] {HUNT, HCRC, PAY, CRC_LO, CRC_HI} state_t;

    state_t            state_reg;
    logic [7:0]        win_reg [HDR_BYTES];
    logic [HIDX_W-1:0] fill_reg;
    logic [HIDX_W-1:0] hidx_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        tlo_reg;
    logic              slot_reg;
    logic [7:0]        type_reg;
    logic [31:0]       seq_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [31:0]       sync_reg;
    logic [7:0]        ver_reg;

    logic        accept;
    logic [31:0] magic;
    logic [15:0] hlen;
    logic        hdr_ok;
    logic        crc_ok;

    assign full   = (state_reg == HCRC) || (q_status.count == 2'd2 && state_reg != HUNT);
    assign accept = push && !full;
    assign magic  = {win_reg[3], win_reg[2], win_reg[1], win_reg[0]};
    assign hlen   = {win_reg[7], win_reg[6]};
    assign hdr_ok = (magic == sync_reg) && (win_reg[4] == ver_reg)
                    && (hlen <= 16'(PAYLOAD_MAX));
    assign crc_ok = ({rx_byte, tlo_reg} == crc_reg);

    assign mem_wr.en   = accept && (state_reg == PAY);
    assign mem_wr.addr = {slot_reg, idx_reg[OFS_W-1:0]};
    assign mem_wr.data = rx_byte;

    assign desc_push         = accept && (state_reg == CRC_HI) && crc_ok;
    assign desc.slot         = slot_reg;
    assign desc.frame_type   = type_reg;
    assign desc.sequence_res = seq_reg;
    assign desc.length       = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HUNT;
            fill_reg  <= '0;
            hidx_reg  <= '0;
            idx_reg   <= '0;
            crc_reg   <= CRC_INIT;
            tlo_reg   <= '0;
            slot_reg  <= 1'b0;
            type_reg  <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            sync_reg  <= '0;
            ver_reg   <= 8'd1;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_SYNC:    sync_reg <= wr_data;
                    REG_VERSION: ver_reg  <= wr_data[7:0];
                    default:     sync_reg <= sync_reg;
                endcase
            end
            unique case (state_reg)
                HUNT:
                begin
                    if (accept)
                    begin
                        if (fill_reg != HIDX_W'(HDR_BYTES - 1))
                        begin
                            win_reg[fill_reg] <= rx_byte;
                            fill_reg          <= fill_reg + 1'b1;
                        end
                        else if (hdr_ok)
                        begin
                            win_reg[HDR_BYTES-1] <= rx_byte;
                            type_reg  <= win_reg[5];
                            len_reg   <= hlen[LEN_W-1:0];
                            seq_reg   <= {rx_byte, win_reg[10], win_reg[9], win_reg[8]};
                            crc_reg   <= CRC_INIT;
                            hidx_reg  <= '0;
                            state_reg <= HCRC;
                        end
                        else
                        begin
                            for (int i = 0; i < HDR_BYTES - 2; i++)
                            begin
                                win_reg[i] <= win_reg[i+1];
                            end
                            win_reg[HDR_BYTES-2] <= rx_byte;
                        end
                    end
                end
                HCRC:
                begin
                    crc_reg <= crc_byte(crc_reg, win_reg[0]);
                    for (int i = 0; i < HDR_BYTES - 1; i++)
                    begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    hidx_reg <= hidx_reg + 1'b1;
                    if (hidx_reg == HIDX_W'(HDR_BYTES - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= (len_reg == '0) ? CRC_LO : PAY;
                    end
                end
                PAY:
                begin
                    if (accept)
                    begin
                        crc_reg <= crc_byte(crc_reg, rx_byte);
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == len_reg)
                        begin
                            state_reg <= CRC_LO;
                        end
                    end
                end
                CRC_LO:
                begin
                    if (accept)
                    begin
                        tlo_reg   <= rx_byte;
                        state_reg <= CRC_HI;
                    end
                end
                CRC_HI:
                begin
                    if (accept)
                    begin
                        if (crc_ok)
                        begin
                            slot_reg <= !slot_reg;
                        end
                        fill_reg  <= '0;
                        state_reg <= HUNT;
                    end
                end
                default: state_reg <= HUNT;
            endcase
        end
    end

endmodule

// ===== rtl/crcd_queue.sv =====
module crcd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_push,
    input  crcd_pkg::desc_t     desc,
    input  logic                desc_pop,
    output crcd_pkg::q_status_t q_status
);
    import crcd_pkg::*;

    desc_t      ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign q_status.count = cnt_reg;
    assign q_status.avail = (cnt_reg != 2'd0);
    assign q_status.head  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (desc_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (desc_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, desc_push} - {1'b0, desc_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            ent_reg[wp_reg] <= desc;
        end
    end

endmodule

// ===== rtl/crcd_back.sv =====
module crcd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  crcd_pkg::mem_wr_t   mem_wr,
    input  crcd_pkg::q_status_t q_status,
    output logic                desc_pop,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          frame_type,
    output logic [31:0]         sequence_res,
    output logic [6:0]          payload_length,
    output logic [7:0]          payload_byte,
    output logic                byte_valid,
    output logic                last
);
    import crcd_pkg::*;

    logic [7:0]       mem [2**ADDR_W];
    logic [LEN_W-1:0] idx_reg;
    logic             valid_reg;
    logic [7:0]       data_reg;
    logic [7:0]       type_reg;
    logic [31:0]      seq_reg;
    logic [LEN_W-1:0] len_reg;
    logic             bv_reg;
    logic             last_reg;

    logic             issue;
    logic             is_last;
    logic [LEN_W-1:0] idx_inc;

    assign issue    = q_status.avail && (!valid_reg || pop);
    assign idx_inc  = idx_reg + 1'b1;
    assign is_last  = (q_status.head.length == '0) || (idx_inc == q_status.head.length);
    assign desc_pop = issue && is_last;

    assign empty          = !valid_reg;
    assign frame_type     = type_reg;
    assign sequence_res   = seq_reg;
    assign payload_length = len_reg;
    assign payload_byte   = bv_reg ? data_reg : 8'h00;
    assign byte_valid     = bv_reg;
    assign last           = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (issue)
        begin
            data_reg <= mem[{q_status.head.slot, idx_reg[OFS_W-1:0]}];
            type_reg <= q_status.head.frame_type;
            seq_reg  <= q_status.head.sequence_res;
            len_reg  <= q_status.head.length;
            bv_reg   <= (q_status.head.length != '0);
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (issue)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : idx_inc;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/crc_checked_frame_deframer.sv =====
// Byte-stream deframer with sync-word hunt and CRC-16 CCITT check.
// Input: one received byte per beat on rx_byte, taken when push is high and
// full is low. Results: one beat per payload byte, with the frame's type,
// sequence and length, the last beat marked; an empty frame gives one beat
// with byte_valid low. Pop a result when empty is low.
// Configuration: wr_en, wr_index (0 sync word, 1 version) and wr_data, written
// only while idle; the block itself does not enforce this.
// Throughput: one byte a cycle while hunting, and while storing payload unless
// two good frames still wait in the queue; after a header matches, full stays
// high while the header CRC runs through the single byte-wide CRC unit.
// After the trailer's high byte, the descriptor is queued and the first
// result is registered; results follow one a cycle while pop stays high.
// Payload storage is two 64-byte slots; a third frame waits (full high) once
// it passes its header while two good frames are still being drained.
// A stalled receiver holds the result; input continues until both slots fill.
// Reset: hunting with an empty window, sync word 0, version 1, no results.
module crc_checked_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  rx_byte,
    output logic        full,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_type,
    output logic [31:0] sequence_res,
    output logic [6:0]  payload_length,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        last
);
    import crcd_pkg::*;

    q_status_t q_status;
    desc_t     desc;
    mem_wr_t   mem_wr;
    logic      desc_push;
    logic      desc_pop;

    crcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .q_status  (q_status),
        .desc_push (desc_push),
        .desc      (desc),
        .mem_wr    (mem_wr)
    );

    crcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_push (desc_push),
        .desc      (desc),
        .desc_pop  (desc_pop),
        .q_status  (q_status)
    );

    crcd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mem_wr         (mem_wr),
        .q_status       (q_status),
        .desc_pop       (desc_pop),
        .empty          (empty),
        .pop            (pop),
        .frame_type     (frame_type),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import crcd_pkg::*;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [31:0] sequence_res;
        logic [6:0]  payload_length;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        last;
    } beat_t;

    typedef enum logic [1:0] {ST_HUNT, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI} rx_state_t;

    class deframe_model;
        logic [31:0] magic_cfg;
        logic [7:0]  version_cfg;
        logic [7:0]  window [12];
        int          fill;
        rx_state_t   state;
        logic [7:0]  f_type;
        logic [6:0]  f_len;
        logic [31:0] f_seq;
        logic [7:0]  store [64];
        logic [6:0]  idx;
        logic [15:0] crc;
        logic [7:0]  trailer_lo;
        beat_t       expected_beats [$];
        int          errors;

        function new();
            magic_cfg = '0;
            version_cfg = 8'd1;
            foreach (window[i]) window[i] = '0;
            fill = 0;
            state = ST_HUNT;
            f_type = '0;
            f_len = '0;
            f_seq = '0;
            idx = '0;
            crc = 16'hFFFF;
            trailer_lo = '0;
            errors = 0;
        endfunction

        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0] len;
            beat_t       e;
            case (state)
                ST_HUNT:
                begin
                    if (fill >= 12)
                    begin
                        fill = 11;
                    end
                    window[fill] = b;
                    fill++;
                    if (fill < 12)
                    begin
                        return;
                    end
                    len = {window[7], window[6]};
                    if ({window[3], window[2], window[1], window[0]} != magic_cfg ||
                        window[4] != version_cfg || len > 16'd64)
                    begin
                        for (int i = 0; i < 11; i++) window[i] = window[i + 1];
                        window[11] = '0;
                        fill = 11;
                        return;
                    end
                    f_type = window[5];
                    f_len = len[6:0];
                    f_seq = {window[11], window[10], window[9], window[8]};
                    crc = 16'hFFFF;
                    for (int i = 0; i < 12; i++) crc = crc16_step(crc, window[i]);
                    idx = '0;
                    fill = 0;
                    foreach (window[i]) window[i] = '0;
                    state = (f_len == 0) ? ST_CRC_LO : ST_PAYLOAD;
                end
                ST_PAYLOAD:
                begin
                    store[idx[5:0]] = b;
                    crc = crc16_step(crc, b);
                    idx = idx + 7'd1;
                    if (idx >= f_len)
                    begin
                        state = ST_CRC_LO;
                    end
                end
                ST_CRC_LO:
                begin
                    trailer_lo = b;
                    state = ST_CRC_HI;
                end
                default:
                begin
                    state = ST_HUNT;
                    fill = 0;
                    idx = '0;
                    if ({b, trailer_lo} != crc)
                    begin
                        return;
                    end
                    e.frame_type = f_type;
                    e.sequence_res = f_seq;
                    if (f_len == 0)
                    begin
                        e.payload_length = '0;
                        e.payload_byte = '0;
                        e.byte_valid = 1'b0;
                        e.last = 1'b1;
                        expected_beats.push_back(e);
                    end
                    else
                    begin
                        for (int i = 0; i < f_len; i++)
                        begin
                            e.payload_length = f_len;
                            e.payload_byte = store[i];
                            e.byte_valid = 1'b1;
                            e.last = (i + 1 == f_len);
                            expected_beats.push_back(e);
                        end
                    end
                end
            endcase
        endfunction

        function void check_beat(beat_t got);
            beat_t e;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result beat %h", got);
                end
                return;
            end
            e = expected_beats.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: type %h/%h seq %h/%h len %0d/%0d byte %h/%h vld %b/%b last %b/%b",
                             e.frame_type, got.frame_type, e.sequence_res, got.sequence_res,
                             e.payload_length, got.payload_length, e.payload_byte,
                             got.payload_byte, e.byte_valid, got.byte_valid, e.last, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic [7:0]  rx_byte;
    logic        full;
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;
    logic        empty;
    logic        pop;
    logic [7:0]  frame_type;
    logic [31:0] sequence_res;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;

    deframe_model model = new();
    bit           idling = 1'b1;
    int           pop_hold = 0;
    int           bytes_sent = 0;
    longint       cycles = 0;

    crc_checked_frame_deframer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .rx_byte        (rx_byte),
        .full           (full),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .empty          (empty),
        .pop            (pop),
        .frame_type     (frame_type),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            model.check_beat('{frame_type, sequence_res, payload_length, payload_byte,
                               byte_valid, last});
        end
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end
        else if (idling && $urandom_range(0, 15) == 0)
        begin
            pop_hold <= $urandom_range(1, 19);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic push_byte(logic [7:0] b);
        if (idling && $urandom_range(0, 15) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        model.note_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (model.expected_beats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] magic, logic [7:0] ver);
        drain();
        wr_en <= 1'b1;
        wr_index <= REG_SYNC;
        wr_data <= magic;
        @(posedge clk);
        wr_index <= REG_VERSION;
        wr_data <= {24'd0, ver};
        @(posedge clk);
        wr_en <= 1'b0;
        model.magic_cfg = magic;
        model.version_cfg = ver;
        @(posedge clk);
    endtask

    task automatic send_frame(logic [31:0] magic, logic [7:0] ver, logic [7:0] ftype,
                              logic [15:0] len, logic [31:0] seq, bit corrupt);
        logic [7:0]  fq [$];
        logic [15:0] c;
        int          n;
        fq = {magic[7:0], magic[15:8], magic[23:16], magic[31:24], ver, ftype,
              len[7:0], len[15:8], seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
        n = (len > 64) ? $urandom_range(0, 6) : int'(len);
        for (int i = 0; i < n; i++) fq.push_back(8'($urandom_range(0, 255)));
        c = 16'hFFFF;
        foreach (fq[i]) c = deframe_model::crc16_step(c, fq[i]);
        if (corrupt)
        begin
            c ^= 16'd1 << $urandom_range(0, 15);
        end
        fq.push_back(c[7:0]);
        fq.push_back(c[15:8]);
        foreach (fq[i]) push_byte(fq[i]);
    endtask

    task automatic random_traffic(int n_bytes);
        int stop_at;
        int pick;
        logic [15:0] len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 64))
                                              : 16'($urandom_range(0, 8));
            if (pick < 70)
            begin
                send_frame(model.magic_cfg, model.version_cfg, 8'($urandom), len, $urandom,
                           1'b0);
            end
            else if (pick < 80)
            begin
                send_frame(model.magic_cfg, model.version_cfg, 8'($urandom), len, $urandom,
                           1'b1);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
            end
            else if (pick < 94)
            begin
                send_frame(model.magic_cfg ^ ($urandom_range(0, 1) << $urandom_range(0, 31)),
                           model.version_cfg ^ 8'($urandom_range(0, 1)), 8'($urandom), len,
                           $urandom, 1'b0);
            end
            else
            begin
                send_frame(model.magic_cfg, model.version_cfg, 8'($urandom),
                           16'($urandom_range(65, 65535)), $urandom, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        rx_byte = '0;
        wr_en = 1'b0;
        wr_index = REG_SYNC;
        wr_data = '0;
        pop = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(32'h0, 8'd1, 8'h00, 16'd0, 32'h0, 1'b0);
        send_frame(32'h0, 8'd1, 8'hFF, 16'd64, 32'hFFFF_FFFF, 1'b0);
        send_frame(32'h0, 8'd1, 8'h5A, 16'd3, 32'h1234_5678, 1'b1);
        send_frame(32'h0, 8'd1, 8'h11, 16'd65, 32'h1, 1'b0);
        send_frame(32'h0, 8'd2, 8'h22, 16'd1, 32'h2, 1'b0);
        send_frame(32'h0, 8'd1, 8'h33, 16'd1, 32'h3, 1'b0);
        random_traffic(20);

        set_config(32'hFFFF_FFFF, 8'hFF);
        send_frame(32'hFFFF_FFFF, 8'hFF, 8'h80, 16'd2, 32'h8000_0000, 1'b0);
        random_traffic(20);

        set_config($urandom, 8'h00);
        random_traffic(20);

        set_config($urandom, 8'($urandom));
        random_traffic(20);
        idling = 1'b0;
        random_traffic(20);

        drain();
        if (model.errors == 0 && model.expected_beats.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
